/* sv/gavc_pkg.sv */
package gavc_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int ITW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
  localparam int XW  = 44;
  localparam int PCW = 4;

  localparam logic [PCW-1:0] PC_IDLE = 4'd0;
  localparam logic [PCW-1:0] PC_EMIT = 4'd11;

  localparam logic [3:0] REG_GOAL_X         = 4'd0;
  localparam logic [3:0] REG_GOAL_Y         = 4'd1;
  localparam logic [3:0] REG_REACHED_THR    = 4'd2;
  localparam logic [3:0] REG_APPROACH_DIST  = 4'd3;
  localparam logic [3:0] REG_APPROACH_SPEED = 4'd4;
  localparam logic [3:0] REG_SPEED_PER_DIST = 4'd5;
  localparam logic [3:0] REG_HEADING_GAIN   = 4'd6;
  localparam logic [3:0] REG_TURN_LIMIT     = 4'd7;

  localparam logic [21:0]        INV_GAIN    = 22'd2547003;
  localparam logic signed [33:0] PI_Q29      = 34'sd1686629713;
  localparam logic signed [33:0] NEG_PI_Q29  = -34'sd1686629713;
  localparam logic signed [33:0] TWO_PI_Q29  = 34'sd3373259426;
  localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;
  localparam logic signed [31:0] NEG_HALF_PI = -32'sd843314857;
  localparam logic [30:0]        MAX31       = 31'h7FFF_FFFF;

  typedef enum logic [1:0] {
    ST_NONE,
    ST_REACHED,
    ST_APPROACH,
    ST_FAR
  } status_t;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_PREROT,
    OP_CORDIC,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_MAGSUM,
    OP_DIST,
    OP_CLASS,
    OP_MUL_TURN,
    OP_MUL_SPD,
    OP_SPEED,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    JC_STEP,
    JC_JUMP,
    JC_IN,
    JC_LOOP,
    JC_EXIT,
    JC_OUT
  } jc_t;

  typedef struct packed {
    op_t            op;
    jc_t            jc;
    logic [PCW-1:0] target;
  } ucw_t;

  typedef struct packed {
    op_t            op;
    logic [ITW-1:0] iter;
    logic           fire;
  } ctrl_t;

  typedef struct packed {
    logic early;
    logic out_free;
  } flags_t;

  typedef struct packed {
    logic signed [31:0] goal_x;
    logic signed [31:0] goal_y;
    logic [30:0]        reached_thr;
    logic [30:0]        approach_dist;
    logic [30:0]        approach_speed;
    logic [23:0]        speed_per_dist;
    logic [23:0]        heading_gain;
    logic [30:0]        turn_limit;
  } cfg_t;

  // Control store: one word per step of the program.
  function automatic ucw_t ucode(input logic [PCW-1:0] pc);
    ucw_t w;
    case (pc)
      4'd0:    w = '{op: OP_IDLE,     jc: JC_IN,   target: PC_EMIT};
      4'd1:    w = '{op: OP_PREROT,   jc: JC_STEP, target: PC_IDLE};
      4'd2:    w = '{op: OP_CORDIC,   jc: JC_LOOP, target: PC_IDLE};
      4'd3:    w = '{op: OP_MUL_LO,   jc: JC_STEP, target: PC_IDLE};
      4'd4:    w = '{op: OP_MUL_HI,   jc: JC_STEP, target: PC_IDLE};
      4'd5:    w = '{op: OP_MAGSUM,   jc: JC_STEP, target: PC_IDLE};
      4'd6:    w = '{op: OP_DIST,     jc: JC_STEP, target: PC_IDLE};
      4'd7:    w = '{op: OP_CLASS,    jc: JC_EXIT, target: PC_EMIT};
      4'd8:    w = '{op: OP_MUL_TURN, jc: JC_STEP, target: PC_IDLE};
      4'd9:    w = '{op: OP_MUL_SPD,  jc: JC_STEP, target: PC_IDLE};
      4'd10:   w = '{op: OP_SPEED,    jc: JC_STEP, target: PC_IDLE};
      4'd11:   w = '{op: OP_EMIT,     jc: JC_OUT,  target: PC_IDLE};
      default: w = '{op: OP_NOP,      jc: JC_JUMP, target: PC_IDLE};
    endcase
    return w;
  endfunction

  // Arctangent of 2^-i in Q29 radians, rounded to nearest.
  function automatic logic signed [31:0] atan_q29(input logic [4:0] i);
    logic signed [31:0] a;
    case (i)
      5'd0:    a = 32'sd421657428;
      5'd1:    a = 32'sd248918915;
      5'd2:    a = 32'sd131521918;
      5'd3:    a = 32'sd66762579;
      5'd4:    a = 32'sd33510843;
      5'd5:    a = 32'sd16771758;
      5'd6:    a = 32'sd8387925;
      5'd7:    a = 32'sd4194219;
      5'd8:    a = 32'sd2097141;
      5'd9:    a = 32'sd1048575;
      5'd10:   a = 32'sd524288;
      5'd11:   a = 32'sd262144;
      5'd12:   a = 32'sd131072;
      5'd13:   a = 32'sd65536;
      5'd14:   a = 32'sd32768;
      5'd15:   a = 32'sd16384;
      5'd16:   a = 32'sd8192;
      5'd17:   a = 32'sd4096;
      5'd18:   a = 32'sd2048;
      5'd19:   a = 32'sd1024;
      5'd20:   a = 32'sd512;
      5'd21:   a = 32'sd256;
      5'd22:   a = 32'sd128;
      5'd23:   a = 32'sd64;
      default: a = 32'sd0;
    endcase
    return a;
  endfunction

endpackage

/* sv/gavc_cfg.sv */
module gavc_cfg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [3:0]    cfg_index,
  input  logic [31:0]   cfg_data,
  input  logic          clr_goal,
  output logic          goal_active,
  output gavc_pkg::cfg_t cfg
);
  import gavc_pkg::*;

  cfg_t cfg_r;
  logic goal_active_r;
  logic wr;

  assign cfg_ready   = 1'b1;
  assign wr          = cfg_valid && cfg_ready;
  assign cfg         = cfg_r;
  assign goal_active = goal_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.goal_x         <= 32'sd0;
      cfg_r.goal_y         <= 32'sd0;
      cfg_r.reached_thr    <= 31'd6554;
      cfg_r.approach_dist  <= 31'd32768;
      cfg_r.approach_speed <= 31'd13107;
      cfg_r.speed_per_dist <= 24'd65536;
      cfg_r.heading_gain   <= 24'd65536;
      cfg_r.turn_limit     <= 31'd65536;
    end else if (wr) begin
      case (cfg_index)
        REG_GOAL_X:         cfg_r.goal_x         <= cfg_data;
        REG_GOAL_Y:         cfg_r.goal_y         <= cfg_data;
        REG_REACHED_THR:    cfg_r.reached_thr    <= cfg_data[30:0];
        REG_APPROACH_DIST:  cfg_r.approach_dist  <= cfg_data[30:0];
        REG_APPROACH_SPEED: cfg_r.approach_speed <= cfg_data[30:0];
        REG_SPEED_PER_DIST: cfg_r.speed_per_dist <= cfg_data[23:0];
        REG_HEADING_GAIN:   cfg_r.heading_gain   <= cfg_data[23:0];
        REG_TURN_LIMIT:     cfg_r.turn_limit     <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // A goal write arms the controller; reaching the goal disarms it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      goal_active_r <= 1'b0;
    end else if (wr && (cfg_index == REG_GOAL_X || cfg_index == REG_GOAL_Y)) begin
      goal_active_r <= 1'b1;
    end else if (clr_goal) begin
      goal_active_r <= 1'b0;
    end
  end

endmodule

/* sv/gavc_seq.sv */
module gavc_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic            goal_active,
  input  gavc_pkg::flags_t flags,
  output gavc_pkg::ctrl_t  ctrl
);
  import gavc_pkg::*;

  logic [PCW-1:0] pc_r, pc_nxt;
  logic [ITW-1:0] iter_r, iter_nxt;
  ucw_t           ucw;
  logic           fire;

  assign ucw = ucode(pc_r);

  always_comb begin
    in_stall  = (ucw.op != OP_IDLE);
    fire      = in_valid && (ucw.op == OP_IDLE);
    ctrl.op   = ucw.op;
    ctrl.iter = iter_r;
    ctrl.fire = fire;
  end

  always_comb begin
    pc_nxt   = pc_r;
    iter_nxt = iter_r;
    case (ucw.jc)
      JC_STEP: pc_nxt = pc_r + 1'b1;
      JC_JUMP: pc_nxt = ucw.target;
      JC_IN: begin
        if (fire) begin
          pc_nxt = goal_active ? pc_r + 1'b1 : ucw.target;
        end
      end
      JC_LOOP: begin
        if (iter_r == ITW'(CORDIC_STEPS - 1)) begin
          pc_nxt   = pc_r + 1'b1;
          iter_nxt = '0;
        end else begin
          iter_nxt = iter_r + 1'b1;
        end
      end
      JC_EXIT: pc_nxt = flags.early ? ucw.target : pc_r + 1'b1;
      JC_OUT: begin
        if (flags.out_free) begin
          pc_nxt = ucw.target;
        end
      end
      default: pc_nxt = PC_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= PC_IDLE;
      iter_r <= '0;
    end else begin
      pc_r   <= pc_nxt;
      iter_r <= iter_nxt;
    end
  end

endmodule

/* sv/gavc_dp.sv */
module gavc_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  gavc_pkg::ctrl_t     ctrl,
  input  gavc_pkg::cfg_t      cfg,
  input  logic signed [31:0]  in_pose_x,
  input  logic signed [31:0]  in_pose_y,
  input  logic signed [15:0]  in_pose_heading,
  output gavc_pkg::flags_t    flags,
  output logic                clr_goal,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [1:0]          out_status,
  output logic [30:0]         out_forward_speed,
  output logic signed [31:0]  out_turn_rate,
  output logic [30:0]         out_goal_distance
);
  import gavc_pkg::*;

  logic signed [XW-1:0] x_r, y_r;
  logic signed [31:0]   z_r;
  logic                 zero_r;
  logic signed [15:0]   hd_r;
  logic signed [57:0]   prod_r;
  logic [63:0]          acc_r;
  logic [30:0]          dist_r;
  logic signed [33:0]   err_r;
  status_t              status_r;
  logic [30:0]          fwd_r;
  logic signed [31:0]   om_r;
  logic                 out_valid_r, out_valid_nxt;
  status_t              out_status_r;
  logic [30:0]          out_fwd_r;
  logic signed [31:0]   out_om_r;
  logic [30:0]          out_dist_r;

  logic signed [32:0]   dx, dy;
  logic signed [XW-1:0] xs, ys;
  logic signed [31:0]   at;
  logic signed [32:0]   mul_a;
  logic signed [24:0]   mul_b;
  logic signed [57:0]   mul_p;
  logic [64:0]          rnd;
  logic [34:0]          dq;
  logic [30:0]          dist_calc;
  logic signed [31:0]   z_eff;
  logic signed [33:0]   err_raw, err_w;
  logic                 reached, far;
  logic signed [58:0]   tsum;
  logic signed [29:0]   tq;
  logic signed [32:0]   tq33, lim33;
  logic signed [32:0]   om33;
  logic [55:0]          vsum;
  logic [39:0]          vq;
  logic [30:0]          vx_calc;
  logic                 emit;

  always_comb begin
    dx = {cfg.goal_x[31], cfg.goal_x} - {in_pose_x[31], in_pose_x};
    dy = {cfg.goal_y[31], cfg.goal_y} - {in_pose_y[31], in_pose_y};
    xs = x_r >>> ctrl.iter;
    ys = y_r >>> ctrl.iter;
    at = atan_q29(5'(ctrl.iter));
  end

  // One shared multiplier; its product is registered before any use.
  always_comb begin
    case (ctrl.op)
      OP_MUL_LO: begin
        mul_a = {11'd0, x_r[21:0]};
        mul_b = {3'd0, INV_GAIN};
      end
      OP_MUL_HI: begin
        mul_a = {12'd0, x_r[42:22]};
        mul_b = {3'd0, INV_GAIN};
      end
      OP_MUL_TURN: begin
        mul_a = {err_r[31], err_r[31:0]};
        mul_b = {1'b0, cfg.heading_gain};
      end
      OP_MUL_SPD: begin
        mul_a = {2'd0, dist_r};
        mul_b = {1'b0, cfg.speed_per_dist};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  always_comb begin
    rnd       = {1'b0, acc_r} + 65'd536870912;
    dq        = rnd[64:30];
    dist_calc = (dq > {4'd0, MAX31}) ? MAX31 : dq[30:0];

    // The bearing is taken as zero when the robot sits exactly on the goal.
    z_eff   = zero_r ? 32'sd0 : z_r;
    err_raw = {{2{z_eff[31]}}, z_eff} - {{2{hd_r[15]}}, hd_r, 16'd0};
    if (err_r > PI_Q29) begin
      err_w = err_r - TWO_PI_Q29;
    end else if (err_r < NEG_PI_Q29) begin
      err_w = err_r + TWO_PI_Q29;
    end else begin
      err_w = err_r;
    end

    reached = dist_r < cfg.reached_thr;
    far     = dist_r >= cfg.approach_dist;

    tsum  = $signed({prod_r[57], prod_r}) + 59'sd268435456;
    tq    = tsum[58:29];
    tq33  = {{3{tq[29]}}, tq};
    lim33 = {2'b00, cfg.turn_limit};
    if (tq33 > lim33) begin
      om33 = lim33;
    end else if (tq33 < -lim33) begin
      om33 = -lim33;
    end else begin
      om33 = tq33;
    end

    vsum = {1'b0, prod_r[54:0]} + 56'd32768;
    vq   = vsum[55:16];
    if (!(dist_r > cfg.reached_thr)) begin
      vx_calc = '0;
    end else if (vq > {9'd0, cfg.approach_speed}) begin
      vx_calc = cfg.approach_speed;
    end else begin
      vx_calc = vq[30:0];
    end
  end

  always_comb begin
    flags.early    = reached || far;
    flags.out_free = !out_valid_r || !out_stall;
    clr_goal       = (ctrl.op == OP_CLASS) && reached;
    emit           = (ctrl.op == OP_EMIT) && flags.out_free;
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_IDLE: begin
        if (ctrl.fire) begin
          x_r      <= {{3{dx[32]}}, dx, 8'd0};
          y_r      <= {{3{dy[32]}}, dy, 8'd0};
          z_r      <= 32'sd0;
          zero_r   <= (dx == 33'sd0) && (dy == 33'sd0);
          hd_r     <= in_pose_heading;
          status_r <= ST_NONE;
          dist_r   <= '0;
          fwd_r    <= '0;
          om_r     <= 32'sd0;
        end
      end
      OP_PREROT: begin
        // Bring the vector into the right half plane first.
        if (x_r[XW-1]) begin
          if (!y_r[XW-1]) begin
            x_r <= y_r;
            y_r <= -x_r;
            z_r <= HALF_PI_Q29;
          end else begin
            x_r <= -y_r;
            y_r <= x_r;
            z_r <= NEG_HALF_PI;
          end
        end
      end
      OP_CORDIC: begin
        if (y_r > 0) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + at;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - at;
        end
      end
      OP_MUL_LO: prod_r <= mul_p;
      OP_MUL_HI: begin
        acc_r  <= {6'd0, prod_r};
        prod_r <= mul_p;
      end
      OP_MAGSUM: acc_r <= acc_r + {prod_r[41:0], 22'd0};
      OP_DIST: begin
        dist_r <= dist_calc;
        err_r  <= err_raw;
      end
      OP_CLASS: begin
        err_r <= err_w;
        if (reached) begin
          status_r <= ST_REACHED;
        end else if (far) begin
          status_r <= ST_FAR;
        end else begin
          status_r <= ST_APPROACH;
        end
      end
      OP_MUL_TURN: prod_r <= mul_p;
      OP_MUL_SPD: begin
        om_r   <= om33[31:0];
        prod_r <= mul_p;
      end
      OP_SPEED: fwd_r <= vx_calc;
      OP_EMIT: begin
        if (emit) begin
          out_status_r <= status_r;
          out_fwd_r    <= fwd_r;
          out_om_r     <= om_r;
          out_dist_r   <= dist_r;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_forward_speed = out_fwd_r;
  assign out_turn_rate     = out_om_r;
  assign out_goal_distance = out_dist_r;

endmodule

/* sv/goal_approach_velocity_controller.sv */
// Channel  Handshake          Payload
// in_      in_valid/in_stall  pose_x, pose_y (Q16.16), pose_heading (Q3.13)
// out_     out_valid/out_stall status, forward_speed, turn_rate, goal_distance
// cfg_     cfg_valid/cfg_ready cfg_index (register number), cfg_data
//
// An active goal runs pre-rotation, the vectoring loop, distance and class steps;
// final approach adds the turn and speed steps, a goal reached or out of range
// skips them, and no goal goes straight to output. Vectoring does one rotation
// per cycle; one multiplier is shared by the distance, turn and speed laws.
// Reset is synchronous and active low; there is no clearing pass.
// A finished result waits in the output register while the next pose is taken.
module goal_approach_velocity_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_pose_x,
  input  logic signed [31:0] in_pose_y,
  input  logic signed [15:0] in_pose_heading,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [30:0]        out_forward_speed,
  output logic signed [31:0] out_turn_rate,
  output logic [30:0]        out_goal_distance,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import gavc_pkg::*;

  cfg_t   cfg;
  ctrl_t  ctrl;
  flags_t flags;
  logic   goal_active;
  logic   clr_goal;

  gavc_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .clr_goal    (clr_goal),
    .goal_active (goal_active),
    .cfg         (cfg)
  );

  gavc_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .goal_active (goal_active),
    .flags       (flags),
    .ctrl        (ctrl)
  );

  gavc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctrl              (ctrl),
    .cfg               (cfg),
    .in_pose_x         (in_pose_x),
    .in_pose_y         (in_pose_y),
    .in_pose_heading   (in_pose_heading),
    .flags             (flags),
    .clr_goal          (clr_goal),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_forward_speed (out_forward_speed),
    .out_turn_rate     (out_turn_rate),
    .out_goal_distance (out_goal_distance)
  );

endmodule

/* sv/gavc_checker.sv */
module gavc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic [30:0]        out_forward_speed,
  input logic signed [31:0] out_turn_rate,
  input logic [30:0]        out_goal_distance
);
  import gavc_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_goal_distance) && $stable(out_turn_rate))
    else $error("stalled result changed");

  // Without a goal every command and the distance are zero.
  a_no_goal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_NONE) |->
      out_forward_speed == '0 && out_turn_rate == '0 && out_goal_distance == '0)
    else $error("non-zero output without a goal");

  // Speeds are only commanded in final approach.
  a_idle_speeds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_REACHED || out_status == ST_FAR) |->
      out_forward_speed == '0 && out_turn_rate == '0)
    else $error("speed commanded outside final approach");

  // One pose is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction taken while busy");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("wrong state after reset");

endmodule

bind goal_approach_velocity_controller gavc_checker u_gavc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_forward_speed (out_forward_speed),
  .out_turn_rate     (out_turn_rate),
  .out_goal_distance (out_goal_distance)
);
